FILE: hw/rtl/var_impulse_response_recursion_macros.svh
// Assertion macros for the impulse-response block.
`ifndef VAR_IMPULSE_RESPONSE_RECURSION_MACROS_SVH
`define VAR_IMPULSE_RESPONSE_RECURSION_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled in reset.
`define VIRR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled in reset.
`define VIRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/virr_pkg.sv
// ----------------------------------------------------------------------------
// virr_pkg
// Beat types, opcodes and shared constants of the impulse-response block.
// ----------------------------------------------------------------------------
package virr_pkg;

    localparam int VALUE_W = 32;
    localparam int ACC_W   = 80;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_ADVANCE  = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAG_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [1:0]                lag_index;
        logic [2:0]                row_index;
        logic [2:0]                col_index;
        logic signed [VALUE_W-1:0] coefficient_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]                horizon;
        logic [2:0]                out_row;
        logic [2:0]                out_col;
        logic signed [VALUE_W-1:0] response_value;
        logic                      last_of_matrix;
        logic                      saturated;
    } out_item_t;

    // Travels with each product term through the multiply-accumulate unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } term_tag_t;

endpackage

FILE: hw/rtl/virr_ram.sv
// ----------------------------------------------------------------------------
// virr_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module virr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/virr_mac.sv
// ----------------------------------------------------------------------------
// virr_mac
// Registered multiply-accumulate with rounding and saturation to Q8.24.
// ----------------------------------------------------------------------------
module virr_mac #(
    parameter int FRAC_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  virr_pkg::term_tag_t                tag,
    input  logic signed [virr_pkg::VALUE_W-1:0] a,
    input  logic signed [virr_pkg::VALUE_W-1:0] b,
    output logic                               done,
    output logic [virr_pkg::VALUE_W-1:0]       result,
    output logic                               saturated
);

    localparam int AW = virr_pkg::ACC_W;
    localparam int VW = virr_pkg::VALUE_W;
    localparam int PW = 2 * VW;

    virr_pkg::term_tag_t   tag_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic                  done_reg;
    logic signed [AW-1:0]  prod_ext;
    logic signed [AW-1:0]  rounded;
    logic signed [AW-1:0]  shifted;
    logic                  fits;

    assign prod_ext = {{(AW - PW){prod_reg[PW-1]}}, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            tag_reg  <= tag;
            done_reg <= tag_reg.valid && tag_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (tag_reg.valid)
        begin
            acc_reg <= tag_reg.first ? prod_ext : acc_reg + prod_ext;
        end
    end

    // Round half up, then check that the upper bits are pure sign.
    assign rounded = acc_reg + (AW'(1) <<< (FRAC_BITS - 1));
    assign shifted = rounded >>> FRAC_BITS;
    assign fits    = (&shifted[AW-1:VW-1]) || !(|shifted[AW-1:VW-1]);

    assign done      = done_reg;
    assign saturated = !fits;
    assign result    = fits ? shifted[VW-1:0]
                     : (shifted[AW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}});

endmodule

FILE: hw/rtl/var_impulse_response_recursion.sv
// ----------------------------------------------------------------------------
// var_impulse_response_recursion
// VAR moving-average (impulse-response) matrix recursion over stored lags.
// ----------------------------------------------------------------------------
// Load and restart beats are finished as they are taken. An advance emits
// the K*K entries of the next response matrix in row-major order; each entry
// after horizon 0 is summed from min(L,h)*K product terms on the single
// multiply-accumulate unit, which reads one coefficient and one history word
// per cycle, and then drains through the pipeline and is written back. The
// block takes a new beat only once every entry of the previous advance has
// been handed to the output register.
`include "var_impulse_response_recursion_macros.svh"

module var_impulse_response_recursion #(
    parameter int MAX_SIZE    = 8,
    parameter int MAX_LAGS    = 4,
    parameter int MAX_HORIZON = 255,
    parameter int FRAC_BITS   = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  virr_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output virr_pkg::out_item_t                 out_data,
    input  logic                                cfg_write_en,
    input  logic [virr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [virr_pkg::CFG_W-1:0]          cfg_data
);

    localparam int VW     = virr_pkg::VALUE_W;
    localparam int MAT    = MAX_SIZE * MAX_SIZE;
    localparam int RING   = MAX_LAGS + 1;
    localparam int CDEPTH = MAX_LAGS * MAT;
    localparam int HDEPTH = RING * MAT;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int HAW    = $clog2(HDEPTH);
    localparam int IW     = $clog2(MAX_SIZE + 1);
    localparam int LW     = $clog2(MAX_LAGS + 1);
    localparam int SW     = $clog2(RING);
    localparam int HW     = $clog2(MAX_HORIZON + 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    logic [3:0]           matrix_size_reg;
    logic [2:0]           lag_count_reg;
    logic [7:0]           horizon_count_reg;
    logic [HW-1:0]        next_h_reg;
    logic [SW-1:0]        slot_reg;
    logic [IW-1:0]        k_reg;
    logic [LW-1:0]        npl_reg;
    logic [IW-1:0]        r_reg;
    logic [IW-1:0]        c_reg;
    logic [IW-1:0]        j_reg;
    logic [LW-1:0]        p_reg;
    logic [SW-1:0]        src_reg;
    virr_pkg::term_tag_t  issue_tag_reg;
    logic                 out_valid_reg;
    virr_pkg::out_item_t  out_data_reg;

    logic [IW-1:0]        k_eff;
    logic [LW-1:0]        l_eff;
    logic [HW-1:0]        last_eff;
    logic [SW-1:0]        src_first;
    logic                 in_accept;
    logic                 out_free;
    logic                 term_first;
    logic                 term_last;
    logic                 entry_last;
    logic                 coeff_we;
    logic [CAW-1:0]       coeff_waddr;
    logic [CAW-1:0]       coeff_raddr;
    logic [VW-1:0]        coeff_rdata;
    logic                 hist_we;
    logic [HAW-1:0]       hist_waddr;
    logic [HAW-1:0]       hist_raddr;
    logic [VW-1:0]        hist_rdata;
    logic                 mac_done;
    logic [VW-1:0]        mac_result;
    logic                 mac_sat;
    logic [VW-1:0]        entry_value;
    logic                 entry_sat;

    // Register values outside the supported range are clamped here.
    always_comb
    begin
        if (matrix_size_reg == 4'd0)
            k_eff = IW'(1);
        else if (int'(matrix_size_reg) > MAX_SIZE)
            k_eff = IW'(MAX_SIZE);
        else
            k_eff = IW'(matrix_size_reg);

        if (lag_count_reg == 3'd0)
            l_eff = LW'(1);
        else if (int'(lag_count_reg) > MAX_LAGS)
            l_eff = LW'(MAX_LAGS);
        else
            l_eff = LW'(lag_count_reg);

        if (int'(horizon_count_reg) < MAX_HORIZON)
            last_eff = HW'(horizon_count_reg);
        else
            last_eff = HW'(MAX_HORIZON);
    end

    assign src_first = (slot_reg == '0) ? SW'(RING - 1) : slot_reg - SW'(1);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign term_first = (p_reg == LW'(1)) && (j_reg == '0);
    assign term_last  = (p_reg == npl_reg) && (j_reg == k_reg - IW'(1));
    assign entry_last = (r_reg == k_reg - IW'(1)) && (c_reg == k_reg - IW'(1));

    assign coeff_we = in_accept && (in_data.opcode == virr_pkg::OP_LOAD)
                   && (int'(in_data.lag_index) < MAX_LAGS)
                   && (int'(in_data.row_index) < MAX_SIZE)
                   && (int'(in_data.col_index) < MAX_SIZE);
    assign coeff_waddr = CAW'(int'(in_data.lag_index) * MAT
                       + int'(in_data.row_index) * MAX_SIZE + int'(in_data.col_index));
    assign coeff_raddr = CAW'((int'(p_reg) - 1) * MAT + int'(r_reg) * MAX_SIZE
                       + int'(j_reg));
    assign hist_raddr  = HAW'(int'(src_reg) * MAT + int'(j_reg) * MAX_SIZE + int'(c_reg));
    assign hist_waddr  = HAW'(int'(slot_reg) * MAT + int'(r_reg) * MAX_SIZE + int'(c_reg));
    assign hist_we     = (state_reg == ST_FINISH) && out_free;

    always_comb
    begin
        if (next_h_reg == '0)
        begin
            entry_value = (r_reg == c_reg) ? (VW'(1) << FRAC_BITS) : '0;
            entry_sat   = 1'b0;
        end
        else
        begin
            entry_value = mac_result;
            entry_sat   = mac_sat;
        end
    end

    virr_ram #(
        .WIDTH (VW),
        .DEPTH (CDEPTH)
    ) u_coeff_ram (
        .clk   (clk),
        .we    (coeff_we),
        .waddr (coeff_waddr),
        .wdata (in_data.coefficient_value),
        .raddr (coeff_raddr),
        .rdata (coeff_rdata)
    );

    virr_ram #(
        .WIDTH (VW),
        .DEPTH (HDEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (entry_value),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    virr_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (issue_tag_reg),
        .a         (coeff_rdata),
        .b         (hist_rdata),
        .done      (mac_done),
        .result    (mac_result),
        .saturated (mac_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            matrix_size_reg   <= 4'd1;
            lag_count_reg     <= 3'd1;
            horizon_count_reg <= 8'd0;
            next_h_reg        <= '0;
            slot_reg          <= '0;
            k_reg             <= IW'(1);
            npl_reg           <= LW'(1);
            r_reg             <= '0;
            c_reg             <= '0;
            j_reg             <= '0;
            p_reg             <= LW'(1);
            src_reg           <= '0;
            issue_tag_reg     <= '0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    virr_pkg::REG_MATRIX_SIZE:   matrix_size_reg   <= cfg_data[3:0];
                    virr_pkg::REG_LAG_COUNT:     lag_count_reg     <= cfg_data[2:0];
                    virr_pkg::REG_HORIZON_COUNT: horizon_count_reg <= cfg_data;
                    default:                     ;
                endcase
            end

            issue_tag_reg.valid <= (state_reg == ST_ISSUE);
            issue_tag_reg.first <= term_first;
            issue_tag_reg.last  <= term_last;

            // In the finish state the output register is reloaded instead.
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (in_data.opcode == virr_pkg::OP_RESTART)
                        begin
                            next_h_reg <= '0;
                            slot_reg   <= '0;
                        end
                        else if ((in_data.opcode == virr_pkg::OP_ADVANCE)
                                 && (next_h_reg <= last_eff))
                        begin
                            k_reg   <= k_eff;
                            npl_reg <= (next_h_reg < HW'(l_eff)) ? LW'(next_h_reg) : l_eff;
                            r_reg   <= '0;
                            c_reg   <= '0;
                            j_reg   <= '0;
                            p_reg   <= LW'(1);
                            src_reg <= src_first;
                            state_reg <= (next_h_reg == '0) ? ST_FINISH : ST_ISSUE;
                        end
                    end
                end

                ST_ISSUE:
                begin
                    if (j_reg == k_reg - IW'(1))
                    begin
                        j_reg <= '0;
                        if (term_last)
                        begin
                            state_reg <= ST_WAIT;
                        end
                        else
                        begin
                            p_reg   <= p_reg + LW'(1);
                            src_reg <= (src_reg == '0) ? SW'(RING - 1) : src_reg - SW'(1);
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + IW'(1);
                    end
                end

                ST_WAIT:
                begin
                    if (mac_done)
                        state_reg <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.horizon         <= 8'(next_h_reg);
                        out_data_reg.out_row         <= 3'(r_reg);
                        out_data_reg.out_col         <= 3'(c_reg);
                        out_data_reg.response_value  <= entry_value;
                        out_data_reg.last_of_matrix  <= entry_last;
                        out_data_reg.saturated       <= entry_sat;
                        if (entry_last)
                        begin
                            next_h_reg <= next_h_reg + HW'(1);
                            slot_reg   <= (slot_reg == SW'(RING - 1)) ? '0
                                        : slot_reg + SW'(1);
                            state_reg  <= ST_IDLE;
                        end
                        else
                        begin
                            if (c_reg == k_reg - IW'(1))
                            begin
                                c_reg <= '0;
                                r_reg <= r_reg + IW'(1);
                            end
                            else
                            begin
                                c_reg <= c_reg + IW'(1);
                            end
                            j_reg     <= '0;
                            p_reg     <= LW'(1);
                            src_reg   <= src_first;
                            state_reg <= (next_h_reg == '0) ? ST_FINISH : ST_ISSUE;
                        end
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `VIRR_ASSERT_NEXT(a_hist_write_loads_out, hist_we, out_valid_reg, "history write without an output beat")
    `VIRR_ASSERT_NOW(a_issue_in_range, state_reg == ST_ISSUE, (j_reg < k_reg) && (p_reg <= npl_reg), "term counters out of range")
    `VIRR_ASSERT_NOW(a_done_in_wait, mac_done, state_reg == ST_WAIT, "accumulation finished outside the wait state")

endmodule
